/* rtl/rtos_task_picker_macros.svh */
// ---------------------------------------------------------------------------
// rtos_task_picker assertion macros
// Concurrent assertion helpers shared by the task picker RTL. Defining
// ASSERT_OFF compiles all checks away.
// ---------------------------------------------------------------------------
`ifndef RTOS_TASK_PICKER_MACROS_SVH
`define RTOS_TASK_PICKER_MACROS_SVH
`ifndef ASSERT_OFF
// The property must hold at every clock edge outside reset.
`define RTP_ASSERT(label, clk, rst, prop) \
label: assert property (@(posedge clk) disable iff (rst) prop) \
   else $error("rtp: assertion failed");
// The condition must never be seen at a clock edge outside reset.
`define RTP_ASSERT_NEVER(label, clk, rst, prop) \
label: assert property (@(posedge clk) disable iff (rst) !(prop)) \
   else $error("rtp: forbidden condition seen");
`else
`define RTP_ASSERT(label, clk, rst, prop)
`define RTP_ASSERT_NEVER(label, clk, rst, prop)
`endif
`endif

/* rtl/rtp_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rtp_pkg
// Types and constants shared by the task picker and its scan cells.
// ---------------------------------------------------------------------------
package rtp_pkg;

   localparam int MAX_TASKS = 16;
   localparam int TASK_W    = $clog2(MAX_TASKS);
   localparam int COUNT_W   = $clog2(MAX_TASKS + 1);
   localparam int PRIO_W    = 8;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = COUNT_W;

   // Request operation codes.
   localparam logic OP_UPDATE   = 1'b0;
   localparam logic OP_SCHEDULE = 1'b1;

   // Scheduling policy codes.
   localparam logic POLICY_RR   = 1'b0;
   localparam logic POLICY_PRIO = 1'b1;

   // Control register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_POLICY_MODE  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_TASKS_IN_USE = CSR_IDX_W'(1);

   typedef struct packed {
      logic              operation;
      logic [TASK_W-1:0] task_index;
      logic              task_is_ready;
      logic [PRIO_W-1:0] task_prio;
   } req_type;

   typedef struct packed {
      logic [TASK_W-1:0] running_task;
      logic              idle_chosen;
   } rsp_type;

   // Entry write broadcast to every cell.
   typedef struct packed {
      logic              en;
      logic [TASK_W-1:0] index;
      logic              ready;
      logic [PRIO_W-1:0] prio;
   } entry_wr_type;

   // Window of the table searched by the running scan.
   typedef struct packed {
      logic [COUNT_W-1:0] n;
      logic [TASK_W-1:0]  lo;
   } scan_bounds_type;

   // Partial search result handed from cell to cell.
   typedef struct packed {
      logic              valid;
      logic              hi_found;
      logic [TASK_W-1:0] hi_idx;
      logic              any_found;
      logic [TASK_W-1:0] any_idx;
      logic              pr_found;
      logic [TASK_W-1:0] pr_idx;
      logic [PRIO_W-1:0] pr_prio;
   } token_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MOD,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

/* rtl/rtos_task_picker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rtos_task_picker
// Task selection for a small real-time kernel: a task table held in a chain
// of scan cells, round-robin or highest-priority pick of the next task.
// ---------------------------------------------------------------------------
// Usage:
// Requests arrive on req_valid/req_ready with a req_data struct. An update
// request writes one table entry; a schedule request picks the next task.
// Every request returns one response on rsp_valid/rsp_ready with the running
// task and an idle flag. The control port (csr_we, csr_index, csr_wdata) sets
// the policy and the entries in use; write it only while the block is idle.
// Flow: an update passes from acceptance through the done state into the
// output register. A schedule request first checks its start point and
// subtracts the entry count until the start point lies inside the table
// (more than once only after the table shrank), then walks the chain of
// scan cells, one per table entry, and registers the result. The block takes
// no new request while one is in progress. The next request is accepted once
// the result sits in the output register; a stalled receiver holds it there
// and a finished result waits until the register is free.
// Reset clears the table and running task and selects round robin, 16 tasks.
// ---------------------------------------------------------------------------
`include "rtos_task_picker_macros.svh"

module rtos_task_picker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  rtp_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output rtp_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  logic [rtp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rtp_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import rtp_pkg::*;

   state_type          state_ff, state_in;

   logic               policy_ff;
   logic [COUNT_W-1:0] tasks_ff;
   logic [TASK_W-1:0]  cur_ff;
   logic [COUNT_W-1:0] n_ff;
   logic [COUNT_W-1:0] m_ff;
   logic [TASK_W-1:0]  lo_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   logic               accept;
   logic               out_free;
   logic               launch;
   logic               finish;
   logic               load_rsp;
   logic [COUNT_W-1:0] n_eff;
   logic [TASK_W-1:0]  pick;

   entry_wr_type       entry_wr;
   scan_bounds_type    bounds;
   token_type          head_tok;
   token_type          tail_tok;
   token_type          chain_tok [MAX_TASKS];
   logic [MAX_TASKS-1:0] tok_valid_vec;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // A count of zero means only the idle task; counts above the table size saturate.
   always_comb begin
      if (tasks_ff == '0) begin
         n_eff = COUNT_W'(1);
      end else if (tasks_ff > COUNT_W'(MAX_TASKS)) begin
         n_eff = COUNT_W'(MAX_TASKS);
      end else begin
         n_eff = tasks_ff;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_data.operation == OP_SCHEDULE) ? ST_MOD : ST_DONE;
            end
         end
         ST_MOD: begin
            if (m_ff < n_ff) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (tail_tok.valid) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State outputs.
   always_comb begin
      req_ready = 1'b0;
      launch    = 1'b0;
      finish    = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_MOD:  launch    = (m_ff < n_ff);
         ST_SCAN: finish    = tail_tok.valid;
         ST_DONE: load_rsp  = out_free;
         default: req_ready = 1'b0;
      endcase
   end

   // Entry writes go straight to the cells when an update is accepted.
   assign entry_wr.en    = accept && (req_data.operation == OP_UPDATE) &&
                           (int'(req_data.task_index) < MAX_TASKS);
   assign entry_wr.index = req_data.task_index;
   assign entry_wr.ready = req_data.task_is_ready;
   assign entry_wr.prio  = req_data.task_prio;

   assign bounds.n  = n_ff;
   assign bounds.lo = lo_ff;

   always_comb begin
      head_tok       = '0;
      head_tok.valid = launch;
   end

   genvar gi;
   generate
      for (gi = 0; gi < MAX_TASKS; gi++) begin : g_cell
         token_type cell_in;
         if (gi == 0) begin : g_head
            assign cell_in = head_tok;
         end else begin : g_link
            assign cell_in = chain_tok[gi-1];
         end
         rtp_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .cell_idx (TASK_W'(gi)),
            .entry_wr (entry_wr),
            .bounds   (bounds),
            .tok_in   (cell_in),
            .tok_out  (chain_tok[gi])
         );
         assign tok_valid_vec[gi] = chain_tok[gi].valid;
      end
   endgenerate

   assign tail_tok = chain_tok[MAX_TASKS-1];

   // Round robin takes the first ready task from the start point on, else the
   // lowest-numbered ready user task, else idle. Priority mode takes the best
   // priority with ties resolved to the lowest index, else idle.
   always_comb begin
      if (policy_ff == POLICY_PRIO) begin
         pick = tail_tok.pr_found ? tail_tok.pr_idx : '0;
      end else if (tail_tok.hi_found) begin
         pick = tail_tok.hi_idx;
      end else if (tail_tok.any_found) begin
         pick = tail_tok.any_idx;
      end else begin
         pick = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         policy_ff    <= POLICY_RR;
         tasks_ff     <= COUNT_W'(MAX_TASKS);
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               CSR_POLICY_MODE:  policy_ff <= csr_wdata[0];
               CSR_TASKS_IN_USE: tasks_ff  <= csr_wdata;
               default:          policy_ff <= policy_ff;
            endcase
         end
         if (finish) begin
            cur_ff <= pick;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // The start point is (current + 1) mod n, reduced by one subtraction per
   // cycle; it needs more than one step only after the table was shrunk.
   always_ff @(posedge clock) begin
      if (accept && (req_data.operation == OP_SCHEDULE)) begin
         n_ff <= n_eff;
         m_ff <= COUNT_W'(cur_ff) + COUNT_W'(1);
      end else if ((state_ff == ST_MOD) && (m_ff >= n_ff)) begin
         m_ff <= m_ff - n_ff;
      end
      if (launch) begin
         lo_ff <= (m_ff == '0) ? TASK_W'(1) : m_ff[TASK_W-1:0];
      end
      if (load_rsp) begin
         rsp_data_ff.running_task <= cur_ff;
         rsp_data_ff.idle_chosen  <= (cur_ff == '0);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `RTP_ASSERT(a_one_token, clock, reset, $countones(tok_valid_vec) <= 1)
   `RTP_ASSERT_NEVER(a_tail_outside_scan, clock, reset, tail_tok.valid && (state_ff != ST_SCAN))
   `RTP_ASSERT(a_mod_bounds, clock, reset, (state_ff == ST_MOD) |-> ((n_ff != '0) && (n_ff <= COUNT_W'(MAX_TASKS))))
   `RTP_ASSERT(a_pick_in_table, clock, reset, ((state_ff == ST_DONE) && ($past(state_ff) == ST_SCAN)) |-> (COUNT_W'(cur_ff) < n_ff))
   `RTP_ASSERT(a_idle_flag, clock, reset, rsp_valid_ff |-> (rsp_data_ff.idle_chosen == (rsp_data_ff.running_task == '0)))

endmodule

/* rtl/rtp_cell.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rtp_cell
// One task table entry plus one stage of the scan chain that folds the entry
// into the search token passing through it.
// ---------------------------------------------------------------------------
module rtp_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [rtp_pkg::TASK_W-1:0]      cell_idx,
   input  rtp_pkg::entry_wr_type           entry_wr,
   input  rtp_pkg::scan_bounds_type        bounds,
   input  rtp_pkg::token_type              tok_in,
   output rtp_pkg::token_type              tok_out
);
   import rtp_pkg::*;

   logic              ready_ff;
   logic [PRIO_W-1:0] prio_ff;
   token_type         tok_ff;
   token_type         tok_in_next;
   logic              qualifies;

   // The idle task and entries beyond the table in use never take part.
   assign qualifies = ready_ff && (cell_idx != '0) && (COUNT_W'(cell_idx) < bounds.n);

   always_comb begin
      tok_in_next = tok_in;
      if (tok_in.valid && qualifies) begin
         if (!tok_in.hi_found && (cell_idx >= bounds.lo)) begin
            tok_in_next.hi_found = 1'b1;
            tok_in_next.hi_idx   = cell_idx;
         end
         if (!tok_in.any_found) begin
            tok_in_next.any_found = 1'b1;
            tok_in_next.any_idx   = cell_idx;
         end
         if (!tok_in.pr_found || (prio_ff > tok_in.pr_prio)) begin
            tok_in_next.pr_found = 1'b1;
            tok_in_next.pr_idx   = cell_idx;
            tok_in_next.pr_prio  = prio_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff <= 1'b0;
         prio_ff  <= '0;
         tok_ff   <= '0;
      end else begin
         if (entry_wr.en && (entry_wr.index == cell_idx)) begin
            ready_ff <= entry_wr.ready;
            prio_ff  <= entry_wr.prio;
         end
         tok_ff <= tok_in_next;
      end
   end

   assign tok_out = tok_ff;

endmodule

/* sim/rtos_task_picker_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rtos_task_picker_tb
// Self-checking regression for the task picker. Requests (table updates and
// schedule decisions) go in through a valid/ready channel, and each response
// is checked against a shadow copy of the task table kept in this bench.
// Directed tests cover reset state, round robin, priority ties and the table
// size limits. Random traffic then runs under several control settings,
// with idle gaps on both channels and a long receiver hold-off.
// ---------------------------------------------------------------------------
module rtos_task_picker_tb;
   import rtp_pkg::*;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int PHASE_COUNT   = 10;
   localparam int PHASE_ITEMS   = 120;
   localparam int HOLDOFF_LEN   = 300;
   localparam int REQ_W         = $bits(req_type);

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   rtos_task_picker u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the task table, the running task and the control
   // registers. It is advanced once for every request the block accepts.
   logic                  shadow_ready [MAX_TASKS];
   logic [PRIO_W-1:0]     shadow_prio  [MAX_TASKS];
   logic [TASK_W-1:0]     shadow_running;
   logic                  shadow_policy;
   logic [CSR_DATA_W-1:0] shadow_count;

   // Picks the block owes us, oldest first.
   rsp_type expected_picks [$];

   int mismatches      = 0;
   int responses_seen  = 0;
   int updates_sent    = 0;
   int schedules_sent  = 0;
   int idle_picks      = 0;
   int settings_used   = 0;
   int cycle_count     = 0;

   // When clear, neither side inserts gaps, so requests go back to back.
   bit idling_on = 1'b1;
   // Set by a test to make the receiver hold off for that many cycles.
   int holdoff_cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // Run limit. It sits far above the slowest correct run, so reaching it
   // means the block stopped answering.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d responses pending.",
                  cycle_count, expected_picks.size());
         $display("rtos_task_picker regression: fail");
         $finish;
      end
   end

   // Table entries actually scanned: zero counts as the idle task alone, and
   // anything above the table size is clipped to it.
   function automatic int entries_in_use();
      int n;
      n = int'(shadow_count);
      if (n < 1)
         n = 1;
      if (n > MAX_TASKS)
         n = MAX_TASKS;
      return n;
   endfunction

   // Applies one accepted request to the shadow table and returns the
   // response that the block must give for it.
   function automatic rsp_type apply_request(req_type r);
      rsp_type   res;
      int        n;
      int        cur;
      int        wraps;
      int        pick;
      bit        done;
      logic [PRIO_W-1:0] best_prio;
      if (r.operation == OP_UPDATE) begin
         shadow_ready[r.task_index] = r.task_is_ready;
         shadow_prio[r.task_index]  = r.task_prio;
      end else begin
         n    = entries_in_use();
         pick = 0;
         done = 1'b0;
         if (shadow_policy == POLICY_PRIO) begin
            // Strictly greater wins, so a tie keeps the lower index.
            best_prio = '0;
            for (int i = 1; i < n; i++) begin
               if (shadow_ready[i] && (!done || shadow_prio[i] > best_prio)) begin
                  pick      = i;
                  best_prio = shadow_prio[i];
                  done      = 1'b1;
               end
            end
         end else begin
            // Step around the table from the running task. The modulo also
            // pulls a running task that lies beyond the table back inside.
            // Passing the idle slot a second time ends the search on idle.
            cur   = int'(shadow_running);
            wraps = 0;
            for (int g = 0; g < 2 * n + 2 && !done; g++) begin
               cur = (cur + 1) % n;
               if (cur == 0) begin
                  wraps++;
                  if (wraps == 2)
                     done = 1'b1;
               end else if (shadow_ready[cur]) begin
                  pick = cur;
                  done = 1'b1;
               end
            end
         end
         shadow_running = TASK_W'(pick);
      end
      res.running_task = shadow_running;
      res.idle_chosen  = (shadow_running == '0);
      return res;
   endfunction

   // Gap length in cycles: one draw in sixteen takes the long range, the rest the short one.
   function automatic int idle_stretch();
      if ($urandom_range(0, 15) == 0)
         return $urandom_range(8, 40);
      return $urandom_range(1, 3);
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("MISMATCH %s: got %0d, expected %0d (response %0d, %0t)",
               what, got, want, responses_seen, $realtime);
      mismatches++;
   endtask

   // Offers one request, holds it until accepted, records the expected
   // response and then maybe leaves the channel idle for a while. Valid is
   // only lowered inside the gap, so back-to-back requests keep it high.
   task automatic send_request(req_type r);
      req_valid <= 1'b1;
      req_data  <= r;
      do
         @(posedge clock);
      while (!req_ready);
      expected_picks.push_back(apply_request(r));
      if (r.operation == OP_UPDATE)
         updates_sent++;
      else
         schedules_sent++;
      if (idling_on && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         repeat (idle_stretch()) @(posedge clock);
      end
   endtask

   task automatic update_entry(int idx, bit rdy, int prio);
      req_type r;
      r.operation     = OP_UPDATE;
      r.task_index    = TASK_W'(idx);
      r.task_is_ready = rdy;
      r.task_prio     = PRIO_W'(prio);
      send_request(r);
   endtask

   task automatic schedule_once();
      req_type r;
      r               = req_type'(REQ_W'($urandom));
      r.operation     = OP_SCHEDULE;
      send_request(r);
   endtask

   // Stops offering requests until every response is in. The block then has
   // nothing in flight and the control registers may be written.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_picks.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // One control write. The trailing edge keeps two writes in a row from
   // lowering and raising the write enable in the same step.
   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, int value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_POLICY_MODE:  shadow_policy = value[0];
         CSR_TASKS_IN_USE: shadow_count  = CSR_DATA_W'(value);
         default: ;
      endcase
      settings_used++;
      @(posedge clock);
   endtask

   // Random request. Updates mostly land inside the table in use so that
   // the scan sees them; priorities often come from a few values to make
   // ties common.
   function automatic req_type random_request(int ready_pct);
      req_type r;
      int      n;
      n               = entries_in_use();
      r               = req_type'(REQ_W'($urandom));
      r.operation     = ($urandom_range(0, 99) < 55) ? OP_UPDATE : OP_SCHEDULE;
      if ($urandom_range(0, 99) < 85)
         r.task_index = TASK_W'($urandom_range(0, n - 1));
      r.task_is_ready = ($urandom_range(0, 99) < ready_pct);
      case ($urandom_range(0, 3))
         0: r.task_prio = PRIO_W'($urandom_range(0, 3) * 85);
         1: r.task_prio = $urandom_range(0, 1) ? '1 : '0;
         default: ;
      endcase
      return r;
   endfunction

   // Response checker: every accepted response is matched, field by field,
   // against the oldest pick still owed.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         responses_seen++;
         if (expected_picks.size() == 0) begin
            report_mismatch("response with no request pending",
                            int'(rsp_data.running_task), -1);
         end else begin
            want = expected_picks.pop_front();
            if (want.idle_chosen)
               idle_picks++;
            if (rsp_data.running_task !== want.running_task)
               report_mismatch("running_task", int'(rsp_data.running_task),
                               int'(want.running_task));
            if (rsp_data.idle_chosen !== want.idle_chosen)
               report_mismatch("idle_chosen", int'(rsp_data.idle_chosen),
                               int'(want.idle_chosen));
         end
      end
   end

   // Receiver. A requested hold-off is counted here in cycles; otherwise the
   // receiver stalls at random while idling is on.
   initial begin
      forever begin
         @(posedge clock);
         if (holdoff_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (holdoff_cycles) @(posedge clock);
            holdoff_cycles = 0;
         end else if (idling_on && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat (idle_stretch()) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Right after reset: nothing is ready, so a schedule request gives idle,
   // and an update request reports the running task unchanged.
   task automatic check_reset_defaults();
      schedule_once();
      update_entry(5, 1'b1, 10);
      schedule_once();
      update_entry(7, 1'b0, 0);
   endtask

   // Round robin across the full table: the idle task's ready bit must never
   // win, the search wraps past the top entry, and with no user task ready
   // the pick falls back to idle.
   task automatic check_round_robin_walk();
      wait_drained();
      csr_write(CSR_POLICY_MODE, int'(POLICY_RR));
      update_entry(0, 1'b1, 255);
      update_entry(15, 1'b1, 255);
      update_entry(5, 1'b0, 10);
      schedule_once();
      schedule_once();
      update_entry(15, 1'b0, 0);
      schedule_once();
      schedule_once();
   endtask

   // Highest priority wins, equal priorities go to the lower index, a
   // not-ready entry is skipped whatever its priority.
   task automatic check_priority_pick();
      wait_drained();
      csr_write(CSR_POLICY_MODE, int'(POLICY_PRIO));
      update_entry(3, 1'b1, 200);
      update_entry(9, 1'b1, 200);
      update_entry(12, 1'b0, 255);
      schedule_once();
      update_entry(12, 1'b1, 255);
      schedule_once();
      update_entry(12, 1'b0, 0);
      schedule_once();
   endtask

   // Table size edges. The running task (12 here) is left outside a
   // four-entry table, then zero entries, then a value beyond the table.
   task automatic check_table_limits();
      wait_drained();
      update_entry(12, 1'b1, 255);
      schedule_once();
      wait_drained();
      csr_write(CSR_POLICY_MODE, int'(POLICY_RR));
      csr_write(CSR_TASKS_IN_USE, 4);
      update_entry(2, 1'b1, 1);
      schedule_once();
      wait_drained();
      csr_write(CSR_TASKS_IN_USE, 0);
      schedule_once();
      wait_drained();
      csr_write(CSR_TASKS_IN_USE, 31);
      schedule_once();
   endtask

   // The receiver stops for a long stretch while requests keep coming, so
   // the block fills up and has to hold its input off.
   task automatic check_receiver_holdoff();
      wait_drained();
      csr_write(CSR_TASKS_IN_USE, MAX_TASKS);
      idling_on      = 1'b0;
      holdoff_cycles = HOLDOFF_LEN;
      repeat (20) send_request(random_request(50));
      wait_drained();
      idling_on = 1'b1;
   endtask

   // Random traffic in phases, each under its own control setting. The first
   // settings hit the extremes; the last ones are drawn at random. Every
   // third phase runs without idle gaps. Now and then the sender stops until
   // every response is back.
   task automatic check_random_traffic();
      int policy_of [PHASE_COUNT];
      int count_of  [PHASE_COUNT];
      int ready_pct;
      policy_of = '{0, 1, 0, 1, 0, 1, 0, 1, 0, 1};
      count_of  = '{16, 16, 1, 0, 31, 2, 17, 5, 3, 16};
      for (int p = 0; p < PHASE_COUNT; p++) begin
         if (p >= PHASE_COUNT - 2) begin
            policy_of[p] = $urandom_range(0, 1);
            count_of[p]  = $urandom_range(0, 31);
         end
         wait_drained();
         csr_write(CSR_POLICY_MODE, policy_of[p]);
         csr_write(CSR_TASKS_IN_USE, count_of[p]);
         idling_on = (p % 3 != 2);
         ready_pct = $urandom_range(15, 90);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            send_request(random_request(ready_pct));
            if ($urandom_range(0, 59) == 0)
               wait_drained();
         end
      end
      idling_on = 1'b1;
   endtask

   initial begin
      for (int i = 0; i < MAX_TASKS; i++) begin
         shadow_ready[i] = 1'b0;
         shadow_prio[i]  = '0;
      end
      shadow_running = '0;
      shadow_policy  = POLICY_RR;
      shadow_count   = CSR_DATA_W'(MAX_TASKS);

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      check_reset_defaults();
      check_round_robin_walk();
      check_priority_pick();
      check_table_limits();
      check_receiver_holdoff();
      check_random_traffic();

      // Let the last responses come out, then keep watching the block in case
      // it sends something nobody asked for.
      wait_drained();
      repeat (40) @(posedge clock);
      if (expected_picks.size() != 0)
         report_mismatch("responses never delivered", 0,
                         expected_picks.size());

      $display("Ran %0d update and %0d schedule requests under %0d control writes.",
               updates_sent, schedules_sent, settings_used);
      $display("Checked %0d responses, %0d of them idle picks; %0d mismatches.",
               responses_seen, idle_picks, mismatches);
      if (mismatches == 0) begin
         $display("rtos_task_picker regression: pass");
      end else begin
         $display("rtos_task_picker regression: fail");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl
rtl/rtp_pkg.sv
rtl/rtp_cell.sv
rtl/rtos_task_picker.sv
sim/rtos_task_picker_tb.sv
